// File: hw/rtl/srv_pkg.sv
package srv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 18;   // input component width
    localparam int OW        = 20;   // output component width
    localparam int SQ_W      = 40;   // radicand width
    localparam int ROOT_W    = 20;   // square root width
    localparam int REM_W     = 22;   // partial remainder width
    localparam int N_CELLS   = ROOT_W;

    localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

    // Everything the back end needs, carried beside the root computation.
    typedef struct packed {
        logic [2:0][OW-1:0] p;
        logic [2:0][DW-1:0] n;
        logic               sat;
    } srv_carry_t;

    typedef struct packed {
        logic [SQ_W-1:0]   x;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        srv_carry_t        carry;
    } srv_cell_t;

endpackage

// File: hw/rtl/srv_front.sv
module srv_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_vld,
    output logic                             in_rdy,
    input  logic [2:0][srv_pkg::DW-1:0]      dir,
    input  logic [2:0][srv_pkg::DW-1:0]      norm,
    input  logic [srv_pkg::DW-1:0]           eta,
    output logic                             out_vld,
    input  logic                             out_rdy,
    output srv_pkg::srv_cell_t               out_data
);
    import srv_pkg::*;

    localparam int NST = 8;
    localparam logic signed [38:0] ONE2  = 39'sd1 <<< (2 * FRAC_BITS);
    localparam logic signed [38:0] RND39 = 39'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [42:0] RND43 = 43'sd1 <<< (FRAC_BITS - 1);

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] rdy;

    // Stage 1: products of the dot product.
    logic signed [35:0]  prod_reg [3];
    logic [2:0][DW-1:0]  d1_reg, n1_reg;
    logic [DW-1:0]       eta1_reg;
    // Stage 2: capped and rounded cosine.
    logic signed [20:0]  c_reg;
    logic [2:0][DW-1:0]  d2_reg, n2_reg;
    logic [DW-1:0]       eta2_reg;
    // Stage 3: cosine times normal.
    logic signed [38:0]  cn_reg [3];
    logic [2:0][DW-1:0]  d3_reg, n3_reg;
    logic [DW-1:0]       eta3_reg;
    // Stage 4: direction plus scaled normal.
    logic signed [23:0]  t_reg [3];
    logic [2:0][DW-1:0]  n4_reg;
    logic [DW-1:0]       eta4_reg;
    // Stage 5: eta times t.
    logic signed [42:0]  et_reg [3];
    logic [2:0][DW-1:0]  n5_reg;
    // Stage 6: perpendicular part, saturated.
    logic [2:0][OW-1:0]  p6_reg;
    logic [2:0][DW-1:0]  n6_reg;
    logic                sat6_reg;
    // Stage 7: squares.
    logic [SQ_W-1:0]     sq_reg [3];
    logic [2:0][OW-1:0]  p7_reg;
    logic [2:0][DW-1:0]  n7_reg;
    logic                sat7_reg;
    // Stage 8 is out_reg.
    srv_cell_t           out_reg;

    logic signed [20:0]  c_next;
    logic signed [23:0]  t_next [3];
    logic [2:0][OW-1:0]  p6_next;
    logic                sat6_next;
    logic [SQ_W-1:0]     x_next;

    always_comb
    begin
        rdy[NST-1] = ~vld_reg[NST-1] | out_rdy;
        for (int k = NST - 2; k >= 0; k--)
        begin
            rdy[k] = ~vld_reg[k] | rdy[k+1];
        end
    end

    assign in_rdy   = rdy[0];
    assign out_vld  = vld_reg[NST-1];
    assign out_data = out_reg;

    always_comb
    begin
        logic signed [37:0] dot;
        logic signed [38:0] c2;
        logic signed [38:0] cr;
        dot = 38'(prod_reg[0]) + 38'(prod_reg[1]) + 38'(prod_reg[2]);
        c2  = -39'(dot);
        if (c2 > ONE2)
        begin
            c2 = ONE2;
        end
        cr     = (c2 + RND39) >>> FRAC_BITS;
        c_next = cr[20:0];
    end

    always_comb
    begin
        logic signed [38:0] tmp;
        for (int i = 0; i < 3; i++)
        begin
            tmp       = ((cn_reg[i] + RND39) >>> FRAC_BITS) + 39'($signed(d3_reg[i]));
            t_next[i] = tmp[23:0];
        end
    end

    always_comb
    begin
        logic signed [42:0] r;
        sat6_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            r = (et_reg[i] + RND43) >>> FRAC_BITS;
            if (r > 43'(OUT_MAX))
            begin
                p6_next[i] = OUT_MAX;
                sat6_next  = 1'b1;
            end
            else if (r < 43'(OUT_MIN))
            begin
                p6_next[i] = OUT_MIN;
                sat6_next  = 1'b1;
            end
            else
            begin
                p6_next[i] = r[OW-1:0];
            end
        end
    end

    always_comb
    begin
        logic [SQ_W+1:0]    l2;
        logic signed [42:0] diff;
        l2   = 42'(sq_reg[0]) + 42'(sq_reg[1]) + 42'(sq_reg[2]);
        diff = 43'(ONE2) - $signed({1'b0, l2});
        if (diff < 0)
        begin
            diff = -diff;
        end
        x_next = diff[SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_vld;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= $signed(dir[i]) * $signed(norm[i]);
            end
            d1_reg   <= dir;
            n1_reg   <= norm;
            eta1_reg <= eta;
        end
        if (rdy[1])
        begin
            c_reg    <= c_next;
            d2_reg   <= d1_reg;
            n2_reg   <= n1_reg;
            eta2_reg <= eta1_reg;
        end
        if (rdy[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                cn_reg[i] <= c_reg * $signed(n2_reg[i]);
            end
            d3_reg   <= d2_reg;
            n3_reg   <= n2_reg;
            eta3_reg <= eta2_reg;
        end
        if (rdy[3])
        begin
            t_reg    <= t_next;
            n4_reg   <= n3_reg;
            eta4_reg <= eta3_reg;
        end
        if (rdy[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                et_reg[i] <= $signed({1'b0, eta4_reg}) * t_reg[i];
            end
            n5_reg <= n4_reg;
        end
        if (rdy[5])
        begin
            p6_reg   <= p6_next;
            n6_reg   <= n5_reg;
            sat6_reg <= sat6_next;
        end
        if (rdy[6])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SQ_W'($signed(p6_reg[i]) * $signed(p6_reg[i]));
            end
            p7_reg   <= p6_reg;
            n7_reg   <= n6_reg;
            sat7_reg <= sat6_reg;
        end
        if (rdy[7])
        begin
            out_reg.x         <= x_next;
            out_reg.rem       <= '0;
            out_reg.root      <= '0;
            out_reg.carry.p   <= p7_reg;
            out_reg.carry.n   <= n7_reg;
            out_reg.carry.sat <= sat7_reg;
        end
    end

`ifndef ASSERT_OFF
    // The capped cosine never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> c_reg <= (21'sd1 <<< FRAC_BITS))
        else $error("cosine above one");
`endif

endmodule

// File: hw/rtl/srv_sqrt_cell.sv
module srv_sqrt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    output logic               in_rdy,
    input  srv_pkg::srv_cell_t in_data,
    output logic               out_vld,
    input  logic               out_rdy,
    output srv_pkg::srv_cell_t out_data
);
    import srv_pkg::*;

    logic      vld_reg;
    srv_cell_t data_reg;
    srv_cell_t data_next;

    assign in_rdy   = ~vld_reg | out_rdy;
    assign out_vld  = vld_reg;
    assign out_data = data_reg;

    // One digit of the restoring square root: bring down two radicand bits
    // and try to subtract 4*root + 1.
    always_comb
    begin
        logic [REM_W+1:0] rem_ext;
        logic [REM_W+1:0] trial;
        rem_ext   = {in_data.rem, in_data.x[SQ_W-1 -: 2]};
        trial     = {2'b00, in_data.root, 2'b01};
        data_next = in_data;
        data_next.x = {in_data.x[SQ_W-3:0], 2'b00};
        if (rem_ext >= trial)
        begin
            data_next.rem  = REM_W'(rem_ext - trial);
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_ext[REM_W-1:0];
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/srv_back.sv
module srv_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_vld,
    output logic                        in_rdy,
    input  srv_pkg::srv_cell_t          in_data,
    output logic                        out_vld,
    input  logic                        out_rdy,
    output logic [2:0][srv_pkg::OW-1:0] out_o,
    output logic                        out_sat
);
    import srv_pkg::*;

    localparam logic signed [38:0] RND39 = 39'sd1 <<< (FRAC_BITS - 1);

    logic               v1_reg, v2_reg;
    logic               rdy1, rdy2;
    logic signed [38:0] sn_reg [3];
    logic [2:0][OW-1:0] p1_reg;
    logic               sat1_reg;
    logic [2:0][OW-1:0] o_reg;
    logic               sat2_reg;
    logic [2:0][OW-1:0] o_next;
    logic               sat_next;

    assign rdy2    = ~v2_reg | out_rdy;
    assign rdy1    = ~v1_reg | rdy2;
    assign in_rdy  = rdy1;
    assign out_vld = v2_reg;
    assign out_o   = o_reg;
    assign out_sat = sat2_reg;

    always_comb
    begin
        logic signed [38:0] o;
        sat_next = sat1_reg;
        for (int i = 0; i < 3; i++)
        begin
            o = 39'($signed(p1_reg[i])) - ((sn_reg[i] + RND39) >>> FRAC_BITS);
            if (o > 39'(OUT_MAX))
            begin
                o_next[i] = OUT_MAX;
                sat_next  = 1'b1;
            end
            else if (o < 39'(OUT_MIN))
            begin
                o_next[i] = OUT_MIN;
                sat_next  = 1'b1;
            end
            else
            begin
                o_next[i] = o[OW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_vld;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sn_reg[i] <= $signed({1'b0, in_data.root}) * $signed(in_data.carry.n[i]);
            end
            p1_reg   <= in_data.carry.p;
            sat1_reg <= in_data.carry.sat;
        end
        if (rdy2)
        begin
            o_reg    <= o_next;
            sat2_reg <= sat_next;
        end
    end

endmodule

// File: hw/rtl/snell_refraction_vector.sv
// Stages from an accepted input transaction to its output transaction:
// 8 front-end stages, one square-root cell per root bit, 2 back-end stages.
// Throughput: one transaction per cycle; every stage stalls only on a full successor.
// Reset (rst_n, asynchronous, active low) clears all valid flags; data registers
// are not reset.
module snell_refraction_vector (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio (18 bits each), 2 zero bits
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z (20 bits each), 4 zero bits
    output logic [63:0]  m_axis_tdata,
    // saturated
    output logic         m_axis_tuser
);
    import srv_pkg::*;

    logic                 cell_vld  [N_CELLS+1];
    logic                 cell_rdy  [N_CELLS+1];
    srv_cell_t            cell_data [N_CELLS+1];
    logic [2:0][OW-1:0]   o;

    srv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s_axis_tvalid),
        .in_rdy   (s_axis_tready),
        .dir      (s_axis_tdata[3*DW-1:0]),
        .norm     (s_axis_tdata[6*DW-1:3*DW]),
        .eta      (s_axis_tdata[7*DW-1:6*DW]),
        .out_vld  (cell_vld[0]),
        .out_rdy  (cell_rdy[0]),
        .out_data (cell_data[0])
    );

    for (genvar k = 0; k < N_CELLS; k++)
    begin : g_cell
        srv_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (cell_vld[k]),
            .in_rdy   (cell_rdy[k]),
            .in_data  (cell_data[k]),
            .out_vld  (cell_vld[k+1]),
            .out_rdy  (cell_rdy[k+1]),
            .out_data (cell_data[k+1])
        );
    end

    srv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (cell_vld[N_CELLS]),
        .in_rdy  (cell_rdy[N_CELLS]),
        .in_data (cell_data[N_CELLS]),
        .out_vld (m_axis_tvalid),
        .out_rdy (m_axis_tready),
        .out_o   (o),
        .out_sat (m_axis_tuser)
    );

    assign m_axis_tdata = {4'b0000, o};

`ifndef ASSERT_OFF
    // With the output register empty, every stage has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    // The input is held off only by a stalled output transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");
    // No result is valid at the output right after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import srv_pkg::*;

    typedef struct {
        logic signed [OW-1:0] x;
        logic signed [OW-1:0] y;
        logic signed [OW-1:0] z;
        logic                 sat;
    } ray_out_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;

    ray_out_t refracted_q[$];
    int       error_count = 0;
    int       hold_cycles = 0;
    int       hold_requests = 0;
    int       hold_seen = 0;
    bit       sink_random = 1;

    localparam int     LONG_HOLD = 120;
    localparam longint ONE2 = 64'sd1 << (2 * FRAC_BITS);

    snell_refraction_vector dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint round_frac(longint v);
        return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint clip20(longint v, inout logic sat);
        if (v > 524287)
        begin
            sat = 1;
            return 524287;
        end
        if (v < -524288)
        begin
            sat = 1;
            return -524288;
        end
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic ray_out_t refract(logic [DW-1:0] dv[3], logic [DW-1:0] nv[3],
                                         logic [DW-1:0] eta);
        longint d[3];
        longint n[3];
        longint p[3];
        longint cos2, cosv, len2, diff, root, t;
        logic   sat;
        ray_out_t r;
        sat = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = longint'($signed(dv[i]));
            n[i] = longint'($signed(nv[i]));
        end
        cos2 = -(d[0] * n[0] + d[1] * n[1] + d[2] * n[2]);
        if (cos2 > ONE2)
            cos2 = ONE2;
        cosv = round_frac(cos2);
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            t = d[i] + round_frac(cosv * n[i]);
            p[i] = clip20(round_frac(longint'({46'd0, eta}) * t), sat);
            len2 += p[i] * p[i];
        end
        diff = ONE2 - len2;
        if (diff < 0)
            diff = -diff;
        root = int_sqrt(diff);
        r.x = OW'(clip20(p[0] - round_frac(root * n[0]), sat));
        r.y = OW'(clip20(p[1] - round_frac(root * n[1]), sat));
        r.z = OW'(clip20(p[2] - round_frac(root * n[2]), sat));
        r.sat = sat;
        return r;
    endfunction

    // Sends one ray after an optional gap and records its expected refraction.
    task automatic send_ray(logic [DW-1:0] dv[3], logic [DW-1:0] nv[3],
                            logic [DW-1:0] eta, int gap);
        repeat (gap)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {2'b0, eta, nv[2], nv[1], nv[0], dv[2], dv[1], dv[0]};
        refracted_q.push_back(refract(dv, nv, eta));
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic idle_source();
        s_axis_tvalid <= 0;
        @(posedge clk);
    endtask

    function automatic int random_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [DW-1:0] unit_ish();
        int k;
        k = $urandom_range(0, 9);
        if (k < 2)
            return DW'($urandom);
        return DW'($signed(int'($urandom_range(0, 2 * 65536)) - 65536));
    endfunction

    task automatic test_directed();
        logic [DW-1:0] d[3];
        logic [DW-1:0] n[3];
        logic [DW-1:0] extremes[4];
        extremes = '{18'h20000, 18'h1FFFF, 18'h00000, 18'h10000};
        // Head-on ray through a unit normal, eta one.
        d = '{18'h0, 18'h0, 18'h30000};
        n = '{18'h0, 18'h0, 18'h10000};
        send_ray(d, n, 18'h10000, 0);
        // Cosine above one is capped.
        d = '{18'h0, 18'h0, 18'h20000};
        send_ray(d, n, 18'h10000, 0);
        // Grazing ray with large eta gives total internal reflection.
        d = '{18'h10000, 18'h0, 18'h0};
        send_ray(d, n, 18'h3FFFF, 0);
        send_ray(d, n, 18'h00000, 1);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
            begin
                d = '{extremes[i], extremes[j], extremes[(i + j) % 4]};
                n = '{extremes[j], extremes[(i + 1) % 4], extremes[i]};
                send_ray(d, n, (i + j) % 2 ? 18'h3FFFF : 18'h08000, 0);
            end
        idle_source();
    endtask

    task automatic test_random(int count);
        logic [DW-1:0] d[3];
        logic [DW-1:0] n[3];
        logic [DW-1:0] eta;
        for (int k = 0; k < count; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d[i] = unit_ish();
                n[i] = unit_ish();
            end
            eta = ($urandom_range(0, 3) == 0) ? DW'($urandom) : DW'($urandom_range(0, 98304));
            send_ray(d, n, eta, random_gap());
        end
        idle_source();
    endtask

    // The sink holds off long enough that the pipeline fills and stalls its input.
    task automatic test_backpressure();
        logic [DW-1:0] d[3];
        logic [DW-1:0] n[3];
        hold_requests++;
        for (int k = 0; k < 60; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d[i] = DW'($urandom);
                n[i] = DW'($urandom);
            end
            send_ray(d, n, DW'($urandom), 0);
        end
        idle_source();
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (refracted_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        ray_out_t e;
        ray_out_t a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a.x   = m_axis_tdata[19:0];
            a.y   = m_axis_tdata[39:20];
            a.z   = m_axis_tdata[59:40];
            a.sat = m_axis_tuser;
            if (refracted_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, a);
                error_count++;
            end
            else
            begin
                e = refracted_q.pop_front();
                if (a.x !== e.x || a.y !== e.y || a.z !== e.z || a.sat !== e.sat)
                begin
                    $display("%0t: expected %p, got %p", $time, e, a);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        int k;
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            m_axis_tready <= 0;
            hold_cycles <= LONG_HOLD;
        end
        else if (hold_cycles > 0)
        begin
            m_axis_tready <= 0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (!sink_random)
            m_axis_tready <= 1;
        else
        begin
            k = $urandom_range(0, 99);
            if (k < 3)
            begin
                m_axis_tready <= 0;
                hold_cycles <= $urandom_range(5, 40);
            end
            else
                m_axis_tready <= (k >= 25);
        end
    end

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        drain();
        test_backpressure();
        drain();
        sink_random = 0;
        test_random(300);
        drain();
        sink_random = 1;
        test_random(570);
        drain();
        if (error_count == 0 && refracted_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/srv_pkg.sv
hw/rtl/srv_front.sv
hw/rtl/srv_sqrt_cell.sv
hw/rtl/srv_back.sv
hw/rtl/snell_refraction_vector.sv
dv/testbench.sv
